// ----- hw/rtl/ngn_pkg.sv -----
package ngn_pkg;

  localparam int DEF_MAX_DIMENSIONS = 6;
  localparam int DEF_TABLE_DEPTH    = 2048;
  localparam int COORD_FIELDS       = 6;
  localparam int COORD_W            = 32;
  localparam int ADDR_FIELD_W       = 11;
  localparam int COMP_W             = 8;
  localparam int DIM_CFG_W          = 3;
  localparam int GRAD_W             = 9;
  localparam int CFG_DATA_W         = 9;
  localparam int CFG_INDEX_W        = 1;
  localparam int VAL_W              = 32;
  localparam int DIV_STEPS          = 32;
  localparam int DIV_CNT_W          = 5;
  localparam int PRIME_W            = 12;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET  = 3'd3;
  localparam logic [GRAD_W-1:0]    GRAD_RESET = 9'd12;
  localparam logic [16:0]          ONE_Q16    = 17'h10000;

  localparam logic [CFG_INDEX_W-1:0] REG_DIMENSION_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_COUNT  = 1'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_CSTART, S_HSQ, S_HPR, S_HACC, S_M1GO, S_M1WAIT, S_IMUL,
    S_M2GO, S_M2WAIT, S_BSET, S_DRD, S_DMUL, S_DACC, S_VWR, S_FSTART,
    S_FA, S_FB, S_FC, S_FD, S_FE, S_FF, S_FG, S_LRD0, S_LRD1, S_LM1,
    S_LM2, S_LWR
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_SQ, MUL_PRIME, MUL_IDX, MUL_DOT, MUL_FADE_A, MUL_FF,
    MUL_TF, MUL_TB, MUL_L1, MUL_L2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_CLR, ACC_HASH, ACC_ADD, ACC_LOAD
  } acc_op_t;

  typedef enum logic [2:0] {
    J_HOLD, J_CLR, J_INC, J_TOP, J_DEC
  } j_op_t;

  typedef struct packed {
    logic     load;
    logic     tbl_we;
    mul_sel_t msel;
    acc_op_t  acc_op;
    j_op_t    j_op;
    logic     ci_clr;
    logic     ci_inc;
    logic     div_start;
    logic     div_tbl;
    logic     base_ld;
    logic     breg_ld;
    logic     treg_ld;
    logic     wreg_ld;
    logic     x1_ld;
    logic     x2_ld;
    logic     vals_we;
    logic     vals_lerp;
    logic     vals_odd;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic j_zero;
    logic corner_last;
    logic pair_last;
    logic div_busy;
  } status_t;

  function automatic logic [PRIME_W-1:0] hash_prime(input logic [2:0] k);
    logic [PRIME_W-1:0] p;
    case (k)
      3'd0: p = 12'd1699;
      3'd1: p = 12'd2237;
      3'd2: p = 12'd2671;
      3'd3: p = 12'd3571;
      3'd4: p = 12'd1949;
      3'd5: p = 12'd2221;
      3'd6: p = 12'd3469;
      default: p = 12'd3083;
    endcase
    return p;
  endfunction

  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    return (v + 66'sd32768) >>> 16;
  endfunction

endpackage

// ----- hw/rtl/ngn_ram.sv -----
module ngn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ngn_mod.sv -----
module ngn_mod import ngn_pkg::*; #(
  parameter int DVW = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [31:0]    dividend,
  input  logic [DVW-1:0] divisor,
  output logic           busy,
  output logic [DVW-1:0] rem
);

  logic [31:0]          num;
  logic [DVW-1:0]       dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVW:0]         trial;

  assign trial = {rem, num[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[30:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= DVW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DVW-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/ngn_dp.sv -----
module ngn_dp import ngn_pkg::*; #(
  parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS,
  parameter int TABLE_DEPTH    = DEF_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [31:0]      coord_0,
  input  logic signed [31:0]      coord_1,
  input  logic signed [31:0]      coord_2,
  input  logic signed [31:0]      coord_3,
  input  logic signed [31:0]      coord_4,
  input  logic signed [31:0]      coord_5,
  input  logic [ADDR_FIELD_W-1:0] table_address,
  input  logic signed [7:0]       table_value,
  output logic signed [31:0]      noise_value,
  input  cmd_t                    cmd,
  output status_t                 st
);

  localparam int JW  = $clog2(MAX_DIMENSIONS);
  localparam int DW  = $clog2(MAX_DIMENSIONS + 1);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int DVW = GRAD_W;
  localparam int BW  = GRAD_W + DW + 1;
  localparam int NC  = 1 << MAX_DIMENSIONS;

  logic [DIM_CFG_W-1:0] dim_cfg;
  logic [GRAD_W-1:0]    grad_cfg;
  logic [COORD_W-1:0]   cin   [COORD_FIELDS];
  logic [COORD_W-1:0]   coord [MAX_DIMENSIONS];
  logic [DW-1:0]        dims_q;
  logic [DW-1:0]        dims_next;
  logic [GRAD_W-1:0]    modq;
  logic [JW-1:0]        j;
  logic [MAX_DIMENSIONS-1:0] ci;
  logic signed [63:0]   acc;
  logic signed [65:0]   prod;
  logic [19:0]          breg;
  logic [16:0]          treg;
  logic [16:0]          wreg;
  logic [VAL_W-1:0]     x1;
  logic [VAL_W-1:0]     x2;
  logic [AW-1:0]        base_addr;
  logic [BW-1:0]        bwork;

  logic [COORD_W-1:0]   cj;
  logic [15:0]          f;
  logic [15:0]          hi;
  logic [DW-1:0]        sh;
  logic                 cbit;
  logic [31:0]          cu32;
  logic signed [17:0]   u;
  logic signed [32:0]   fa;
  logic signed [32:0]   ma;
  logic signed [32:0]   mb;
  logic [COMP_W-1:0]    tbl_rdata;
  logic [VAL_W-1:0]     vals_rdata;
  logic [AW:0]          tsum;
  logic [AW-1:0]        taddr;
  logic signed [65:0]   fade_r;
  logic signed [65:0]   lsum;
  logic signed [65:0]   lrnd;
  logic [VAL_W-1:0]     lres;
  logic [DVW-1:0]       rem;
  logic                 div_busy;
  logic                 red_busy;
  logic [MAX_DIMENSIONS:0]   ncm;
  logic [MAX_DIMENSIONS-1:0] hm;
  logic                 tbl_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_cfg  <= DIM_RESET;
      grad_cfg <= GRAD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIMENSION_COUNT: dim_cfg  <= cfg_data[DIM_CFG_W-1:0];
        REG_GRADIENT_COUNT:  grad_cfg <= cfg_data[GRAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cin[0] = coord_0;
  assign cin[1] = coord_1;
  assign cin[2] = coord_2;
  assign cin[3] = coord_3;
  assign cin[4] = coord_4;
  assign cin[5] = coord_5;

  for (genvar k = 0; k < MAX_DIMENSIONS; k++) begin : g_coord
    if (k < COORD_FIELDS) begin : g_field
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          coord[k] <= cin[k];
        end
      end
    end else begin : g_zero
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          coord[k] <= '0;
        end
      end
    end
  end

  always_comb begin
    if (int'(dim_cfg) < 2) begin
      dims_next = DW'(2);
    end else if (int'(dim_cfg) > MAX_DIMENSIONS) begin
      dims_next = DW'(MAX_DIMENSIONS);
    end else begin
      dims_next = DW'(dim_cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dims_q <= dims_next;
      modq   <= (grad_cfg == '0) ? GRAD_W'(1) : grad_cfg;
    end
  end

  assign cj   = coord[j];
  assign f    = cj[15:0];
  assign hi   = cj[31:16];
  assign sh   = dims_q - DW'(1) - DW'(j);
  assign cbit = ci[sh[JW-1:0]];
  assign cu32 = {{16{hi[15]}}, hi} + 32'(cbit);
  assign u    = $signed({2'b00, f}) - (cbit ? 18'sd65536 : 18'sd0);
  assign fa   = $signed({17'b0, f}) * 33'sd6 - 33'sd983040;

  always_comb begin
    case (cmd.msel)
      MUL_SQ: begin
        ma = {1'b0, cu32};
        mb = {1'b0, cu32};
      end
      MUL_PRIME: begin
        ma = {1'b0, prod[31:0]};
        mb = {21'b0, hash_prime(3'(j))};
      end
      MUL_IDX: begin
        ma = {{(33 - DVW){1'b0}}, rem};
        mb = {{(33 - DW){1'b0}}, dims_q};
      end
      MUL_DOT: begin
        ma = 33'(u);
        mb = 33'($signed(tbl_rdata));
      end
      MUL_FADE_A: begin
        ma = fa;
        mb = {17'b0, f};
      end
      MUL_FF: begin
        ma = {17'b0, f};
        mb = {17'b0, f};
      end
      MUL_TF: begin
        ma = {16'b0, treg};
        mb = {17'b0, f};
      end
      MUL_TB: begin
        ma = {16'b0, treg};
        mb = {13'b0, breg};
      end
      MUL_L1: begin
        ma = 33'($signed(x1));
        mb = {16'b0, 17'(ONE_Q16 - wreg)};
      end
      MUL_L2: begin
        ma = 33'($signed(x2));
        mb = {16'b0, wreg};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.msel != MUL_NONE) begin
      prod <= 66'(ma) * 66'(mb);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_CLR:  acc <= '0;
      ACC_HASH: acc <= {32'b0, acc[31:0] + prod[31:0]};
      ACC_ADD:  acc <= acc + 64'(prod);
      ACC_LOAD: acc <= 64'(prod);
      default:  acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else begin
      case (cmd.j_op)
        J_CLR:   j <= '0;
        J_INC:   j <= j + 1'b1;
        J_TOP:   j <= JW'(dims_q - DW'(1));
        J_DEC:   j <= j - 1'b1;
        default: j <= j;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
    end else if (cmd.ci_clr) begin
      ci <= '0;
    end else if (cmd.ci_inc) begin
      ci <= ci + 1'b1;
    end
  end

  // The table base address is reduced into range by repeated subtraction.
  assign red_busy = (bwork >= BW'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      bwork <= '0;
    end else if (cmd.div_tbl) begin
      bwork <= prod[BW-1:0];
    end else if (red_busy) begin
      bwork <= bwork - BW'(TABLE_DEPTH);
    end
  end

  assign fade_r = rnd16(prod);
  assign lsum   = 66'(acc) + prod;
  assign lrnd   = rnd16(lsum);
  assign lres   = lrnd[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.breg_ld) begin
      breg <= 20'(rnd16(prod + 66'sd42949672960));
    end
    if (cmd.treg_ld) begin
      treg <= 17'(fade_r);
    end
    if (cmd.wreg_ld) begin
      if (fade_r > 66'sd65536) begin
        wreg <= ONE_Q16;
      end else if (fade_r < 66'sd0) begin
        wreg <= '0;
      end else begin
        wreg <= 17'(fade_r);
      end
    end
    if (cmd.x1_ld) begin
      x1 <= vals_rdata;
    end
    if (cmd.x2_ld) begin
      x2 <= vals_rdata;
    end
    if (cmd.base_ld) begin
      base_addr <= bwork[AW-1:0];
    end
    if (cmd.out_ld) begin
      noise_value <= lres;
    end
  end

  ngn_mod #(.DVW(DVW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc[31:0]),
    .divisor  (modq),
    .busy     (div_busy),
    .rem      (rem)
  );

  assign tsum   = (AW + 1)'(base_addr) + (AW + 1)'(j);
  assign taddr  = (tsum >= (AW + 1)'(TABLE_DEPTH)) ? AW'(tsum - (AW + 1)'(TABLE_DEPTH))
                                                   : tsum[AW-1:0];
  assign tbl_we = cmd.tbl_we && (32'(table_address) < TABLE_DEPTH);

  ngn_ram #(.WIDTH(COMP_W), .DEPTH(TABLE_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(table_address)),
    .wdata (table_value),
    .raddr (taddr),
    .rdata (tbl_rdata)
  );

  ngn_ram #(.WIDTH(VAL_W), .DEPTH(NC)) u_vals (
    .clk   (clk),
    .we    (cmd.vals_we),
    .waddr (ci),
    .wdata (cmd.vals_lerp ? lres : acc[VAL_W-1:0]),
    .raddr ({ci[MAX_DIMENSIONS-2:0], cmd.vals_odd}),
    .rdata (vals_rdata)
  );

  assign ncm = ((MAX_DIMENSIONS + 1)'(1) << dims_q) - 1'b1;
  assign hm  = (MAX_DIMENSIONS'(1) << j) - 1'b1;

  assign st.j_last      = (DW'(j) == dims_q - DW'(1));
  assign st.j_zero      = (j == '0);
  assign st.corner_last = (ci == ncm[MAX_DIMENSIONS-1:0]);
  assign st.pair_last   = (ci == hm);
  assign st.div_busy    = div_busy | red_busy;

endmodule

// ----- hw/rtl/ngn_ctrl.sv -----
module ngn_ctrl import ngn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    opcode,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (opcode == OP_EVAL) begin
            cmd.load   = 1'b1;
            cmd.ci_clr = 1'b1;
            state_next = S_CSTART;
          end else begin
            cmd.tbl_we = 1'b1;
          end
        end
      end
      S_CSTART: begin
        cmd.acc_op = ACC_CLR;
        cmd.j_op   = J_CLR;
        state_next = S_HSQ;
      end
      S_HSQ: begin
        cmd.msel   = MUL_SQ;
        state_next = S_HPR;
      end
      S_HPR: begin
        cmd.msel   = MUL_PRIME;
        state_next = S_HACC;
      end
      S_HACC: begin
        cmd.acc_op = ACC_HASH;
        if (st.j_last) begin
          state_next = S_M1GO;
        end else begin
          cmd.j_op   = J_INC;
          state_next = S_HSQ;
        end
      end
      S_M1GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_M1WAIT;
      end
      S_M1WAIT: begin
        if (!st.div_busy) begin
          state_next = S_IMUL;
        end
      end
      S_IMUL: begin
        cmd.msel   = MUL_IDX;
        state_next = S_M2GO;
      end
      S_M2GO: begin
        cmd.div_tbl = 1'b1;
        state_next  = S_M2WAIT;
      end
      S_M2WAIT: begin
        if (!st.div_busy) begin
          state_next = S_BSET;
        end
      end
      S_BSET: begin
        cmd.base_ld = 1'b1;
        cmd.acc_op  = ACC_CLR;
        cmd.j_op    = J_CLR;
        state_next  = S_DRD;
      end
      S_DRD: begin
        state_next = S_DMUL;
      end
      S_DMUL: begin
        cmd.msel   = MUL_DOT;
        state_next = S_DACC;
      end
      S_DACC: begin
        cmd.acc_op = ACC_ADD;
        if (st.j_last) begin
          state_next = S_VWR;
        end else begin
          cmd.j_op   = J_INC;
          state_next = S_DRD;
        end
      end
      S_VWR: begin
        cmd.vals_we = 1'b1;
        if (st.corner_last) begin
          state_next = S_FSTART;
        end else begin
          cmd.ci_inc = 1'b1;
          state_next = S_CSTART;
        end
      end
      S_FSTART: begin
        cmd.j_op   = J_TOP;
        state_next = S_FA;
      end
      S_FA: begin
        cmd.msel   = MUL_FADE_A;
        state_next = S_FB;
      end
      S_FB: begin
        cmd.breg_ld = 1'b1;
        cmd.msel    = MUL_FF;
        state_next  = S_FC;
      end
      S_FC: begin
        cmd.treg_ld = 1'b1;
        state_next  = S_FD;
      end
      S_FD: begin
        cmd.msel   = MUL_TF;
        state_next = S_FE;
      end
      S_FE: begin
        cmd.treg_ld = 1'b1;
        state_next  = S_FF;
      end
      S_FF: begin
        cmd.msel   = MUL_TB;
        state_next = S_FG;
      end
      S_FG: begin
        cmd.wreg_ld = 1'b1;
        cmd.ci_clr  = 1'b1;
        state_next  = S_LRD0;
      end
      S_LRD0: begin
        state_next = S_LRD1;
      end
      S_LRD1: begin
        cmd.vals_odd = 1'b1;
        cmd.x1_ld    = 1'b1;
        state_next   = S_LM1;
      end
      S_LM1: begin
        cmd.x2_ld  = 1'b1;
        cmd.msel   = MUL_L1;
        state_next = S_LM2;
      end
      S_LM2: begin
        cmd.acc_op = ACC_LOAD;
        cmd.msel   = MUL_L2;
        state_next = S_LWR;
      end
      S_LWR: begin
        if (st.pair_last && st.j_zero) begin
          if (!out_valid || out_ready) begin
            cmd.out_ld = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.vals_we   = 1'b1;
          cmd.vals_lerp = 1'b1;
          if (st.pair_last) begin
            cmd.j_op   = J_DEC;
            state_next = S_FA;
          end else begin
            cmd.ci_inc = 1'b1;
            state_next = S_LRD0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_out_ld_final: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (st.pair_last && st.j_zero))
    else $error("result loaded before the last fold step");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!out_valid || out_ready))
    else $error("result register overwritten while stalled");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !st.div_busy)
    else $error("modulo unit started while busy");

  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !st.div_busy)
    else $error("input ready while modulo unit busy");

  a_out_valid_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |=> out_valid)
    else $error("result not presented after load");
`endif

endmodule

// ----- hw/rtl/nd_gradient_noise_eval_unit.sv -----
// N-dimensional gradient noise evaluator with a loadable gradient table.
// The input channel (in_valid/in_ready) carries one item: opcode selects a
// table write (table_address, table_value) or a noise evaluation at the
// Q16.16 point coord_0..coord_5. A write item is accepted in the idle state
// and gives no result. An evaluate item gives one noise_value on the output
// channel (out_valid/out_ready).
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and sets dimension_count and gradient_count between items.
// One item is processed at a time. An evaluation is paced by the bit-serial
// modulo unit, which runs once per corner, and by the single shared
// multiplier.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a later evaluation holds at its last step.
// Reset is synchronous and restores the configuration registers to their
// defaults; the gradient table contents are undefined until written.
module nd_gradient_noise_eval_unit import ngn_pkg::*; #(
  parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS,
  parameter int TABLE_DEPTH    = DEF_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic signed [31:0]      coord_0,
  input  logic signed [31:0]      coord_1,
  input  logic signed [31:0]      coord_2,
  input  logic signed [31:0]      coord_3,
  input  logic signed [31:0]      coord_4,
  input  logic signed [31:0]      coord_5,
  input  logic [ADDR_FIELD_W-1:0] table_address,
  input  logic signed [7:0]       table_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [31:0]      noise_value
);

  cmd_t    cmd;
  status_t st;

  ngn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ngn_dp #(
    .MAX_DIMENSIONS (MAX_DIMENSIONS),
    .TABLE_DEPTH    (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .coord_0       (coord_0),
    .coord_1       (coord_1),
    .coord_2       (coord_2),
    .coord_3       (coord_3),
    .coord_4       (coord_4),
    .coord_5       (coord_5),
    .table_address (table_address),
    .table_value   (table_value),
    .noise_value   (noise_value),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

// ----- tb/nd_gradient_noise_eval_unit_test.sv -----
`timescale 1ns / 100ps

module nd_gradient_noise_eval_unit_test import ngn_pkg::*;;

  localparam int  TBL_DEPTH  = 2048;
  localparam int  TBL_FILL   = 420;
  localparam int  MAX_DIMS   = 6;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic                    op;
    logic [5:0][31:0]        coords;
    logic [ADDR_FIELD_W-1:0] addr;
    logic [7:0]              value;
  } noise_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    opcode = OP_WRITE;
  logic signed [31:0]      coord_0 = '0;
  logic signed [31:0]      coord_1 = '0;
  logic signed [31:0]      coord_2 = '0;
  logic signed [31:0]      coord_3 = '0;
  logic signed [31:0]      coord_4 = '0;
  logic signed [31:0]      coord_5 = '0;
  logic [ADDR_FIELD_W-1:0] table_address = '0;
  logic signed [7:0]       table_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [31:0]      noise_value;

  noise_item_t pending_items[$];
  logic [31:0] expected_noise[$];

  logic signed [7:0]     grad_mem [TBL_DEPTH];
  logic [DIM_CFG_W-1:0]  dim_reg = DIM_RESET;
  logic [GRAD_W-1:0]     grad_reg = GRAD_RESET;

  logic   in_fire = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_mode = 0;
  int     stall_phase = 0;
  longint cycle_count = 0;
  int     error_count = 0;

  nd_gradient_noise_eval_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .coord_0(coord_0), .coord_1(coord_1), .coord_2(coord_2),
    .coord_3(coord_3), .coord_4(coord_4), .coord_5(coord_5),
    .table_address(table_address), .table_value(table_value),
    .out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint round_half_up(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint fade_weight(longint f);
    longint a, b, t2, t3, r;
    a = 6 * f - 15 * 65536;
    b = round_half_up(a * f + (64'sd10 <<< 32));
    t2 = round_half_up(f * f);
    t3 = round_half_up(t2 * f);
    r = round_half_up(t3 * b);
    if (r > 65536) r = 65536;
    if (r < 0) r = 0;
    return r;
  endfunction

  function automatic logic [31:0] noise_at(logic [5:0][31:0] c);
    int unsigned dims, modulus, corners, half, idx, bitv;
    longint base_int [MAX_DIMS];
    longint frac [MAX_DIMS];
    longint vals [64];
    logic [31:0] hsum, cu, sq;
    logic [11:0] prime;
    longint dot, u, w;
    dims = dim_reg;
    if (dims < 2) dims = 2;
    if (dims > MAX_DIMS) dims = MAX_DIMS;
    modulus = (grad_reg == 0) ? 1 : grad_reg;
    for (int j = 0; j < dims; j++) begin
      base_int[j] = longint'($signed(c[j][31:16]));
      frac[j] = longint'({1'b0, c[j][15:0]});
    end
    corners = 1 << dims;
    for (int i = 0; i < corners; i++) begin
      hsum = '0;
      for (int j = 0; j < dims; j++) begin
        bitv = (i >> (dims - 1 - j)) & 1;
        cu = 32'(base_int[j] + bitv);
        sq = cu * cu;
        prime = hash_prime(3'(j));
        hsum = hsum + sq * {20'd0, prime};
      end
      idx = hsum % modulus;
      dot = 0;
      for (int j = 0; j < dims; j++) begin
        bitv = (i >> (dims - 1 - j)) & 1;
        u = frac[j] - (bitv ? 65536 : 0);
        dot += u * longint'(grad_mem[(idx * dims + j) % TBL_DEPTH]);
      end
      vals[i] = dot;
    end
    for (int j = dims; j > 0; j--) begin
      half = corners >> 1;
      w = fade_weight(frac[j - 1]);
      for (int i = 0; i < half; i++) begin
        vals[i] = round_half_up(vals[2 * i] * (65536 - w) + vals[2 * i + 1] * w);
      end
      corners = half;
    end
    return vals[0][31:0];
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] x;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 5))
          0: x = 32'h7FFF_FFFF;
          1: x = 32'h8000_0000;
          2: x = 32'h0000_0000;
          3: x = 32'h0000_FFFF;
          4: x = 32'hFFFF_0000;
          default: x = 32'h0001_0000;
        endcase
      end
      1, 2: x = {16'($signed($urandom_range(0, 8)) - 4), 16'($urandom)};
      default: x = $urandom;
    endcase
    return x;
  endfunction

  function automatic noise_item_t eval_item();
    noise_item_t it;
    it.op = OP_EVAL;
    for (int k = 0; k < 6; k++) it.coords[k] = pick_coord();
    it.addr = ADDR_FIELD_W'($urandom);
    it.value = 8'($urandom);
    return it;
  endfunction

  function automatic noise_item_t write_item(int span);
    noise_item_t it;
    it.op = OP_WRITE;
    for (int k = 0; k < 6; k++) it.coords[k] = $urandom;
    if ($urandom_range(0, 1) == 0 && span > 0)
      it.addr = ADDR_FIELD_W'($urandom_range(0, span - 1));
    else
      it.addr = ADDR_FIELD_W'($urandom);
    case ($urandom_range(0, 7))
      0: it.value = 8'h80;
      1: it.value = 8'h7F;
      default: it.value = 8'($urandom);
    endcase
    return it;
  endfunction

  task automatic queue_item(noise_item_t it);
    pending_items = {pending_items, it};
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= in_valid;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      noise_item_t it;
      it = pending_items.pop_front();
      opcode <= it.op;
      coord_0 <= it.coords[0];
      coord_1 <= it.coords[1];
      coord_2 <= it.coords[2];
      coord_3 <= it.coords[3];
      coord_4 <= it.coords[4];
      coord_5 <= it.coords[5];
      table_address <= it.addr;
      table_value <= it.value;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: a stall pattern is picked at random and held for a random time.
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(100, 600);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= (cycle_count % 7) > 2;
      2: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else if (!rst) begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_noise.size() == 0) begin
          $error("unexpected noise_value %h", noise_value);
          error_count++;
        end else begin
          logic [31:0] want;
          want = expected_noise.pop_front();
          if (noise_value !== want) begin
            $error("noise_value expected %h actual %h", want, noise_value);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (opcode == OP_EVAL) begin
          expected_noise = {expected_noise, noise_at({coord_5, coord_4, coord_3,
                                                      coord_2, coord_1, coord_0})};
        end else begin
          grad_mem[table_address] = table_value;
        end
      end
    end else begin
      in_fire <= 1'b0;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_noise.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_DIMENSION_COUNT) dim_reg = DIM_CFG_W'(value);
    else grad_reg = GRAD_W'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int dims_set [9] = '{2, 4, 6, 2, 0, 7, 3, 5, 2};
    int grad_set [9] = '{1, 97, 70, 200, 0, 5, 140, 84, 2};
    int count_set [9] = '{30, 25, 10, 30, 30, 10, 30, 15, 30};
    noise_item_t it;
    int span;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int a = 0; a < TBL_FILL; a++) begin
      it = write_item(0);
      it.addr = ADDR_FIELD_W'(a);
      queue_item(it);
    end
    it = write_item(0);
    it.addr = '0;
    it.value = 8'h80;
    queue_item(it);
    it.addr = ADDR_FIELD_W'(TBL_DEPTH - 1);
    it.value = 8'h7F;
    queue_item(it);
    for (int k = 0; k < 6; k++) begin
      it = eval_item();
      for (int j = 0; j < 6; j++) begin
        case (k)
          0: it.coords[j] = 32'h0000_0000;
          1: it.coords[j] = 32'h7FFF_FFFF;
          2: it.coords[j] = 32'h8000_0000;
          3: it.coords[j] = 32'h0000_FFFF;
          4: it.coords[j] = 32'hFFFF_8000;
          default: it.coords[j] = 32'h0001_0000 * j;
        endcase
      end
      queue_item(it);
    end
    for (int k = 0; k < 12; k++) queue_item(eval_item());
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      repeat (50) @(posedge clk);
      write_reg(REG_DIMENSION_COUNT, dims_set[p]);
      write_reg(REG_GRADIENT_COUNT, grad_set[p]);
      span = ((grad_set[p] == 0) ? 1 : grad_set[p]) * 6;
      if (span > TBL_FILL) span = TBL_FILL;
      for (int k = 0; k < count_set[p]; k++) begin
        if ($urandom_range(0, 9) < 7) queue_item(eval_item());
        else queue_item(write_item(span));
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
